/* rtl/core/bdvg_pkg.sv */
`timescale 1ns / 1ps
package bdvg_pkg;

   localparam int RadW         = 30;
   localparam int RootW        = 15;
   localparam int RemW         = 17;
   localparam int SqrtStages   = 5;
   localparam int StepsPerStage = 3;
   // dist/abs stage, multiply stage, root stages, limit stage
   localparam int WallLat      = SqrtStages + 3;

   localparam logic signed [15:0] MAG_SAT = 16'sd32767;

   localparam logic [2:0] REG_X_MIN = 3'd0;
   localparam logic [2:0] REG_X_MAX = 3'd1;
   localparam logic [2:0] REG_Y_MIN = 3'd2;
   localparam logic [2:0] REG_Y_MAX = 3'd3;
   localparam logic [2:0] REG_Z_MIN = 3'd4;
   localparam logic [2:0] REG_Z_MAX = 3'd5;
   localparam logic [2:0] REG_DECEL = 3'd6;

   localparam logic signed [15:0] RST_X_MIN = -16'sd3000;
   localparam logic signed [15:0] RST_X_MAX = 16'sd3000;
   localparam logic signed [15:0] RST_Y_MIN = -16'sd3000;
   localparam logic signed [15:0] RST_Y_MAX = 16'sd3000;
   localparam logic signed [15:0] RST_Z_MIN = 16'sd100;
   localparam logic signed [15:0] RST_Z_MAX = 16'sd3000;
   localparam logic [15:0]        RST_DECEL = 16'd2000;

   typedef struct packed {
      logic signed [15:0] x_min;
      logic signed [15:0] x_max;
      logic signed [15:0] y_min;
      logic signed [15:0] y_max;
      logic signed [15:0] z_min;
      logic signed [15:0] z_max;
      logic [15:0]        decel;
   } cfg_type;

   typedef struct packed {
      logic sat;
      logic neg;
   } wall_tag_type;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [RadW-1:0]  rad;
   } sqrt_acc_type;

   // one restoring step: bring down two radicand bits, try to set the next root bit
   function automatic sqrt_acc_type sqrt_step(sqrt_acc_type a);
      sqrt_acc_type     res;
      logic [RemW-1:0]  trial;
      logic [RemW-1:0]  test;
      trial    = {a.rem[RemW-3:0], a.rad[RadW-1:RadW-2]};
      test     = {a.root, 2'b01};
      res.rad  = {a.rad[RadW-3:0], 2'b00};
      if (trial >= test) begin
         res.rem  = trial - test;
         res.root = {a.root[RootW-2:0], 1'b1};
      end else begin
         res.rem  = trial;
         res.root = {a.root[RootW-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

/* rtl/core/bdvg_csr.sv */
`timescale 1ns / 1ps
module bdvg_csr
   import bdvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_X_MIN: cfg_in.x_min = csr_pwdata[15:0];
            REG_X_MAX: cfg_in.x_max = csr_pwdata[15:0];
            REG_Y_MIN: cfg_in.y_min = csr_pwdata[15:0];
            REG_Y_MAX: cfg_in.y_max = csr_pwdata[15:0];
            REG_Z_MIN: cfg_in.z_min = csr_pwdata[15:0];
            REG_Z_MAX: cfg_in.z_max = csr_pwdata[15:0];
            REG_DECEL: cfg_in.decel = csr_pwdata[15:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_X_MIN: csr_prdata = {16'd0, cfg_ff.x_min};
         REG_X_MAX: csr_prdata = {16'd0, cfg_ff.x_max};
         REG_Y_MIN: csr_prdata = {16'd0, cfg_ff.y_min};
         REG_Y_MAX: csr_prdata = {16'd0, cfg_ff.y_max};
         REG_Z_MIN: csr_prdata = {16'd0, cfg_ff.z_min};
         REG_Z_MAX: csr_prdata = {16'd0, cfg_ff.z_max};
         REG_DECEL: csr_prdata = {16'd0, cfg_ff.decel};
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min <= RST_X_MIN;
         cfg_ff.x_max <= RST_X_MAX;
         cfg_ff.y_min <= RST_Y_MIN;
         cfg_ff.y_max <= RST_Y_MAX;
         cfg_ff.z_min <= RST_Z_MIN;
         cfg_ff.z_max <= RST_Z_MAX;
         cfg_ff.decel <= RST_DECEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/bdvg_isqrt.sv */
`timescale 1ns / 1ps
module bdvg_isqrt
   import bdvg_pkg::*;
(
   input  logic               clock,
   input  logic               advance,
   input  logic [RadW-1:0]    rad,
   input  wall_tag_type       tag_in,
   output logic [RootW-1:0]   root,
   output wall_tag_type       tag_out
);

   sqrt_acc_type acc_ff [SqrtStages];
   sqrt_acc_type acc_in [SqrtStages];
   wall_tag_type tag_ff [SqrtStages];

   for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
      always_comb begin
         sqrt_acc_type a;
         if (s == 0) begin
            a.rem  = '0;
            a.root = '0;
            a.rad  = rad;
         end else begin
            a = acc_ff[(s == 0) ? 0 : s-1];
         end
         for (int k = 0; k < StepsPerStage; k++) begin
            a = sqrt_step(a);
         end
         acc_in[s] = a;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[s] <= acc_in[s];
            tag_ff[s] <= (s == 0) ? tag_in : tag_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign root    = acc_ff[SqrtStages-1].root;
   assign tag_out = tag_ff[SqrtStages-1];

endmodule

/* rtl/core/bdvg_wall.sv */
`timescale 1ns / 1ps
module bdvg_wall
   import bdvg_pkg::*;
(
   input  logic               clock,
   input  logic               advance,
   input  logic signed [15:0] pos,
   input  logic signed [15:0] wall,
   input  logic [15:0]        decel,
   output logic signed [15:0] limit
);

   logic signed [16:0] diff;
   logic [16:0]        dist_abs;
   logic [15:0]        dist_ff;
   logic               neg_ff;
   logic [31:0]        prod_ff;
   logic               neg_b_ff;
   wall_tag_type       tag_b;
   wall_tag_type       tag_r;
   logic [RootW-1:0]   root;
   logic signed [15:0] mag;
   logic signed [15:0] limit_in;
   logic signed [15:0] limit_ff;

   assign diff     = 17'(pos) - 17'(wall);
   assign dist_abs = diff[16] ? 17'(-diff) : 17'(diff);

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff  <= dist_abs[15:0];
         neg_ff   <= !diff[16] && (diff != 17'sd0);
         prod_ff  <= dist_ff * decel;
         neg_b_ff <= neg_ff;
         limit_ff <= limit_in;
      end
   end

   // radicand is 2*prod; anything at or above 2^30 has a root past the saturation point
   assign tag_b.sat = |prod_ff[31:29];
   assign tag_b.neg = neg_b_ff;

   bdvg_isqrt u_isqrt (
      .clock   (clock),
      .advance (advance),
      .rad     ({prod_ff[28:0], 1'b0}),
      .tag_in  (tag_b),
      .root    (root),
      .tag_out (tag_r)
   );

   assign mag      = tag_r.sat ? MAG_SAT : signed'({1'b0, root});
   assign limit_in = tag_r.neg ? -mag : mag;
   assign limit    = limit_ff;

endmodule

/* rtl/core/braking_distance_velocity_geofence.sv */
`timescale 1ns / 1ps
// Stopping-distance velocity limiter for a box geofence. Each request carries a position
// and a requested velocity; for every axis and wall the block computes the fastest speed
// that still stops at the wall, floor(sqrt(2*decel*|pos-wall|)) saturated to 32767, signed
// toward the wall, and clamps the request between the low and high wall limits. One request
// enters per cycle unless the output stalls; it passes distance, multiply, a five-stage
// square root (three root bits per stage), the limit stage and the clamp/output register.
// A stalled response holds the whole pipe. Box walls and deceleration live in seven 16-bit
// registers at byte addresses 0x00..0x18 and should be written only while the pipe is empty.
module braking_distance_velocity_geofence
   import bdvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // pos_x, pos_y, pos_z, req_vx, req_vy, req_vz
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // lim_vx, lim_vy, lim_vz, changed, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type            cfg;
   logic               advance;
   logic               valid_ff [WallLat];
   logic [47:0]        vel_ff   [WallLat];
   logic signed [15:0] pos   [3];
   logic signed [15:0] w_lo  [3];
   logic signed [15:0] w_hi  [3];
   logic signed [15:0] lim_lo [3];
   logic signed [15:0] lim_hi [3];
   logic signed [15:0] req_v [3];
   logic signed [15:0] out_v [3];
   logic [2:0]         diff_v;
   logic               rsp_valid_ff;
   logic [48:0]        rsp_data_ff;
   logic [48:0]        rsp_data_in;

   bdvg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance every stage together whenever the output slot frees up
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign pos[0]  = req_tdata[15:0];
   assign pos[1]  = req_tdata[31:16];
   assign pos[2]  = req_tdata[47:32];
   assign w_lo[0] = cfg.x_min;
   assign w_hi[0] = cfg.x_max;
   assign w_lo[1] = cfg.y_min;
   assign w_hi[1] = cfg.y_max;
   assign w_lo[2] = cfg.z_min;
   assign w_hi[2] = cfg.z_max;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      bdvg_wall u_lo (
         .clock   (clock),
         .advance (advance),
         .pos     (pos[a]),
         .wall    (w_lo[a]),
         .decel   (cfg.decel),
         .limit   (lim_lo[a])
      );
      bdvg_wall u_hi (
         .clock   (clock),
         .advance (advance),
         .pos     (pos[a]),
         .wall    (w_hi[a]),
         .decel   (cfg.decel),
         .limit   (lim_hi[a])
      );

      assign req_v[a] = vel_ff[WallLat-1][16*a +: 16];

      always_comb begin
         logic signed [15:0] v;
         v = (req_v[a] < lim_lo[a]) ? lim_lo[a] : req_v[a];
         out_v[a]  = (v > lim_hi[a]) ? lim_hi[a] : v;
         diff_v[a] = (out_v[a] != req_v[a]);
      end
   end

   assign rsp_data_in = {|diff_v, out_v[2], out_v[1], out_v[0]};

   for (genvar s = 0; s < WallLat; s++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= (s == 0) ? (req_tvalid && req_tready)
                                    : valid_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            vel_ff[s] <= (s == 0) ? req_tdata[95:48] : vel_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[WallLat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

`ifndef ASSERT_OFF
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff[0]) && $stable(valid_ff[WallLat-1]) && $stable(rsp_data_ff))
      else $error("pipeline moved during a stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted request missing from first stage");

   a_tail_delivers: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[WallLat-1] && advance) |=> rsp_valid_ff)
      else $error("last stage request not moved to output");
`endif

endmodule
